// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the retry backoff RTL.
// Relies on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rbd assertion failed");
`define RBD_NEVER(lbl, cond) `RBD_ASSERT(lbl, !(cond))
`else
`define RBD_ASSERT(lbl, prop)
`define RBD_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/rbd_pkg.sv =====
// Package for the retry backoff decider: codes, constants, queue entry type.
// No dependencies.
`default_nettype none
package rbd_pkg;

    // Outcome codes
    localparam logic [1:0] OUTCOME_RETRY         = 2'd0;
    localparam logic [1:0] OUTCOME_NOT_RETRYABLE = 2'd1;
    localparam logic [1:0] OUTCOME_EXHAUSTED     = 2'd2;

    // Operation codes
    localparam logic OP_HEADER_CHAR = 1'b0;
    localparam logic OP_EVALUATE    = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY_MS  = 2'd2;

    localparam logic [7:0]  MAX_ATTEMPTS_RST  = 8'd3;
    localparam logic [31:0] BASE_DELAY_MS_RST = 32'd1000;
    localparam logic [31:0] MAX_DELAY_MS_RST  = 32'd60000;

    // Retryable statuses
    localparam logic [9:0] ST_TOO_MANY   = 10'd429;
    localparam logic [9:0] ST_INTERNAL   = 10'd500;
    localparam logic [9:0] ST_BAD_GW     = 10'd502;
    localparam logic [9:0] ST_UNAVAIL    = 10'd503;
    localparam logic [9:0] ST_GW_TIMEOUT = 10'd504;

    // Header characters
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam int MAX_HEADER_DIGITS_DEF = 9;
    localparam int EXP_CAP  = 20;
    localparam int EXP_W    = 5;
    localparam int DELAY_W  = 32;
    localparam int SHIFT_W  = DELAY_W + EXP_CAP;
    localparam int MS_MUL_W = 10;   // bits to hold the factor 1000
    localparam int Q_DEPTH  = 2;

    // Bits needed for a decimal number of the given digit count
    function automatic int sec_width(input int digits);
        longint v;
        int     w;
        v = 1;
        w = 0;
        for (int i = 0; i < digits; i++) begin
            v = v * 10;
        end
        v = v - 1;
        while (v > 0) begin
            w++;
            v = v >> 1;
        end
        return w;
    endfunction

    typedef struct packed {
        logic [1:0]       outcome;
        logic [EXP_W-1:0] exponent;
        logic             hdr_ok;
    } ev_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rbd_front.sv =====
// Front end: Retry-After parser and evaluate classification.
// Depends on rbd_pkg.
`default_nettype none
module rbd_front #(
    parameter int MAX_HEADER_DIGITS = rbd_pkg::MAX_HEADER_DIGITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 operation,
    input  wire logic [7:0]           header_char,
    input  wire logic [9:0]           status,
    input  wire logic                 no_response,
    input  wire logic [7:0]           attempt,
    input  wire logic [7:0]           max_attempts,
    output rbd_pkg::ev_ctrl_t         ev_ctrl,
    output logic [rbd_pkg::sec_width(MAX_HEADER_DIGITS)+rbd_pkg::MS_MUL_W-1:0] header_ms,
    output logic                      push
);
    import rbd_pkg::*;

    localparam int SECW = sec_width(MAX_HEADER_DIGITS);
    localparam int MSW  = SECW + MS_MUL_W;
    localparam int CNTW = $clog2(MAX_HEADER_DIGITS + 2);

    logic [SECW-1:0] seconds_reg, seconds_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            invalid_reg, invalid_next;

    logic            is_blank, is_digit;
    logic [CNTW-1:0] cnt_inc;
    logic [SECW-1:0] seconds_x10;
    logic [MSW-1:0]  sec_ext;
    logic            retryable;
    logic [7:0]      limit;
    logic [7:0]      att_m1;

    assign is_blank = (header_char == CH_SPACE) ||
                      (header_char >= CH_TAB && header_char <= CH_CR);
    assign is_digit = (header_char >= CH_ZERO) && (header_char <= CH_NINE);
    assign cnt_inc  = count_reg + 1'b1;
    assign seconds_x10 = (seconds_reg << 3) + (seconds_reg << 1);

    always_comb
    begin
        seconds_next = seconds_reg;
        count_next   = count_reg;
        invalid_next = invalid_reg;
        if (accept && operation == OP_EVALUATE)
        begin
            seconds_next = '0;
            count_next   = '0;
            invalid_next = 1'b0;
        end
        else if (accept && !invalid_reg && !is_blank)
        begin
            if (!is_digit)
            begin
                invalid_next = 1'b1;
            end
            else
            begin
                count_next = cnt_inc;
                if (cnt_inc > CNTW'(MAX_HEADER_DIGITS))
                    invalid_next = 1'b1;
                else
                    seconds_next = seconds_x10 + SECW'(header_char - CH_ZERO);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg <= '0;
            count_reg   <= '0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            seconds_reg <= seconds_next;
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
        end
    end

    // Classify the evaluate beat
    assign retryable = no_response ||
                       status == ST_TOO_MANY || status == ST_INTERNAL ||
                       status == ST_BAD_GW   || status == ST_UNAVAIL  ||
                       status == ST_GW_TIMEOUT;
    assign limit  = (max_attempts == 8'd0) ? 8'd1 : max_attempts;
    assign att_m1 = attempt - 8'd1;

    always_comb
    begin
        if (!retryable)
            ev_ctrl.outcome = OUTCOME_NOT_RETRYABLE;
        else if (attempt >= limit)
            ev_ctrl.outcome = OUTCOME_EXHAUSTED;
        else
            ev_ctrl.outcome = OUTCOME_RETRY;

        if (attempt == 8'd0)
            ev_ctrl.exponent = '0;
        else if (att_m1 > 8'(EXP_CAP))
            ev_ctrl.exponent = EXP_W'(EXP_CAP);
        else
            ev_ctrl.exponent = att_m1[EXP_W-1:0];

        ev_ctrl.hdr_ok = !invalid_reg && (count_reg != '0);
    end

    // seconds * 1000 = s*1024 - s*16 - s*8
    assign sec_ext   = MSW'(seconds_reg);
    assign header_ms = (sec_ext << 10) - (sec_ext << 4) - (sec_ext << 3);
    assign push      = accept && (operation == OP_EVALUATE);

endmodule
`default_nettype wire

// ===== hw/rtl/rbd_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on rbd_pkg.
`default_nettype none
module rbd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output logic              full,
    output logic              empty
);
    import rbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rbd_back.sv =====
// Back end: backoff shift, caps and the result register.
// Depends on rbd_pkg.
`default_nettype none
module rbd_back #(
    parameter int MSW = rbd_pkg::sec_width(rbd_pkg::MAX_HEADER_DIGITS_DEF) + rbd_pkg::MS_MUL_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire rbd_pkg::ev_ctrl_t             ev_ctrl,
    input  wire logic [MSW-1:0]                header_ms,
    input  wire logic [rbd_pkg::DELAY_W-1:0]   base_delay_ms,
    input  wire logic [rbd_pkg::DELAY_W-1:0]   max_delay_ms,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               retry,
    output logic [rbd_pkg::DELAY_W-1:0]        delay_ms,
    output logic [1:0]                         outcome
);
    import rbd_pkg::*;

    localparam int CMPW = (MSW > DELAY_W) ? MSW : DELAY_W;

    logic [SHIFT_W-1:0] shifted;
    logic [DELAY_W-1:0] backoff_cap, header_cap, delay_sel;
    logic [CMPW-1:0]    hdr_ext, max_ext;

    logic               valid_reg, valid_next;
    logic               retry_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [1:0]         outcome_reg;

    assign shifted     = SHIFT_W'(base_delay_ms) << ev_ctrl.exponent;
    assign backoff_cap = (shifted > SHIFT_W'(max_delay_ms)) ? max_delay_ms
                                                             : shifted[DELAY_W-1:0];
    assign hdr_ext     = CMPW'(header_ms);
    assign max_ext     = CMPW'(max_delay_ms);
    assign header_cap  = (hdr_ext > max_ext) ? max_delay_ms : hdr_ext[DELAY_W-1:0];

    always_comb
    begin
        if (ev_ctrl.outcome != OUTCOME_RETRY)
            delay_sel = '0;
        else if (ev_ctrl.hdr_ok)
            delay_sel = header_cap;
        else
            delay_sel = backoff_cap;
    end

    // Load a new beat when the result register is free or being drained
    assign pop        = !q_empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            retry_reg   <= (ev_ctrl.outcome == OUTCOME_RETRY);
            delay_reg   <= delay_sel;
            outcome_reg <= ev_ctrl.outcome;
        end
    end

    assign out_valid = valid_reg;
    assign retry     = retry_reg;
    assign delay_ms  = delay_reg;
    assign outcome   = outcome_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/retry_backoff_decider.sv =====
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | operation, header_char, status, no_response, attempt
//  out     | out_valid / out_stall| retry, delay_ms, outcome
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One beat per cycle in while in_stall is low; header characters update the parser
//  in the cycle they are taken, evaluate beats are classified by the front end and
//  written to the queue, then shifted and capped by the back end into the result
//  register. The two-entry queue sets how long the input keeps flowing while
//  out_stall holds. Reset is asynchronous, active low, and restores the
//  configuration defaults and an empty parser.
`default_nettype none
`include "assert_macros.svh"
module retry_backoff_decider #(
    parameter int MAX_HEADER_DIGITS = rbd_pkg::MAX_HEADER_DIGITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           operation,
    input  wire logic [7:0]                     header_char,
    input  wire logic [9:0]                     status,
    input  wire logic                           no_response,
    input  wire logic [7:0]                     attempt,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                retry,
    output logic [rbd_pkg::DELAY_W-1:0]         delay_ms,
    output logic [1:0]                          outcome,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::DELAY_W-1:0]    cfg_data
);
    import rbd_pkg::*;

    localparam int SECW = sec_width(MAX_HEADER_DIGITS);
    localparam int MSW  = SECW + MS_MUL_W;
    localparam int CTW  = $bits(ev_ctrl_t);
    localparam int QW   = CTW + MSW;

    logic [7:0]         max_attempts_reg;
    logic [DELAY_W-1:0] base_delay_reg;
    logic [DELAY_W-1:0] max_delay_reg;

    logic               accept;
    logic               push, pop, q_full, q_empty;
    ev_ctrl_t           front_ctrl, back_ctrl;
    logic [MSW-1:0]     front_ms, back_ms;
    logic [QW-1:0]      q_out;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            base_delay_reg   <= BASE_DELAY_MS_RST;
            max_delay_reg    <= MAX_DELAY_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ATTEMPTS:  max_attempts_reg <= cfg_data[7:0];
                CFG_BASE_DELAY_MS: base_delay_reg   <= cfg_data;
                CFG_MAX_DELAY_MS:  max_delay_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input while the queue is full
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    rbd_front #(
        .MAX_HEADER_DIGITS(MAX_HEADER_DIGITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .header_char  (header_char),
        .status       (status),
        .no_response  (no_response),
        .attempt      (attempt),
        .max_attempts (max_attempts_reg),
        .ev_ctrl      (front_ctrl),
        .header_ms    (front_ms),
        .push         (push)
    );

    rbd_queue #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_ctrl, front_ms}),
        .pop       (pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign back_ctrl = q_out[QW-1:MSW];
    assign back_ms   = q_out[MSW-1:0];

    rbd_back #(
        .MSW(MSW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .ev_ctrl       (back_ctrl),
        .header_ms     (back_ms),
        .base_delay_ms (base_delay_reg),
        .max_delay_ms  (max_delay_reg),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .retry         (retry),
        .delay_ms      (delay_ms),
        .outcome       (outcome)
    );

    // A declined request never carries a wait
    `RBD_ASSERT(a_no_retry_zero_delay, out_valid && !retry |-> delay_ms == '0)
    // The retry flag and the outcome code agree
    `RBD_ASSERT(a_retry_matches_outcome, out_valid |-> (retry == (outcome == OUTCOME_RETRY)))
    // A fresh result only appears after the queue held an entry
    `RBD_ASSERT(a_result_from_queue, $rose(out_valid) |-> $past(!q_empty))

endmodule
`default_nettype wire
